### hdl/tnc_pkg.sv
// Package for the triangle normal and centroid block.
// Shared constants, field widths and the controller/datapath command struct.
// No dependencies.
package tnc_pkg;

	localparam int MAX_VERTICES_DEF = 4096;
	localparam int IDX_W   = 12;
	localparam int COORD_W = 24;
	localparam int NORM_W  = 32;
	localparam int LEN_W   = 32;
	// cross components need 51 bits of magnitude, S needs 102 bits
	localparam int CROSS_W = 52;
	localparam int SUM_W   = 102;
	localparam int ROOT_W  = 51;
	localparam int QUO_W   = 31;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TRI   = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       rd_en;     // issue a store read
		logic [1:0] rd_sel;    // which corner: 0=a 1=b 2=c
		logic [1:0] cap_sel;   // capture registered read into corner slot
		logic       cap_en;
		logic       edge_en;   // form sums and edge differences
		logic       mul_en;    // one product step
		logic [2:0] mul_step;  // product step index
		logic       sq_en;     // square step
		logic [1:0] sq_step;
		logic       root_init;
		logic       root_en;   // one root bit
		logic       div_init;  // load divider for a component
		logic [1:0] div_sel;
		logic       div_en;    // one quotient bit
		logic       div_store;
		logic       cen_en;    // centroid division step
	} tnc_cmd_t;

	typedef struct packed {
		logic root_done;
		logic div_done;
		logic degen;
	} tnc_sts_t;

endpackage

### hdl/tnc_datapath.sv
// Datapath of the triangle normal and centroid block.
// Vertex store, cross product, sequential square root and shared divider.
// Depends on tnc_pkg.
module tnc_datapath #(
	parameter int MAX_VERTICES = tnc_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tnc_pkg::tnc_cmd_t             cmd,
	output tnc_pkg::tnc_sts_t             sts,
	input  logic                          wr_en,
	input  logic [tnc_pkg::IDX_W-1:0]     wr_idx,
	input  logic [tnc_pkg::IDX_W-1:0]     idx_a,
	input  logic [tnc_pkg::IDX_W-1:0]     idx_b,
	input  logic [tnc_pkg::IDX_W-1:0]     idx_c,
	input  logic signed [tnc_pkg::COORD_W-1:0] wx,
	input  logic signed [tnc_pkg::COORD_W-1:0] wy,
	input  logic signed [tnc_pkg::COORD_W-1:0] wz,
	output logic signed [tnc_pkg::COORD_W-1:0] cen_x,
	output logic signed [tnc_pkg::COORD_W-1:0] cen_y,
	output logic signed [tnc_pkg::COORD_W-1:0] cen_z,
	output logic signed [tnc_pkg::NORM_W-1:0]  nrm_x,
	output logic signed [tnc_pkg::NORM_W-1:0]  nrm_y,
	output logic signed [tnc_pkg::NORM_W-1:0]  nrm_z,
	output logic [tnc_pkg::LEN_W-1:0]          nrm_len
);
	import tnc_pkg::*;

	// entries beyond the index range can never be addressed
	localparam int DEPTH = (MAX_VERTICES < (1 << IDX_W)) ? MAX_VERTICES : (1 << IDX_W);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW = 3 * COORD_W;
	localparam int EW = COORD_W + 1;
	localparam int PW = 2 * EW;
	localparam int SW = COORD_W + 2;
	localparam int CW = 32;

	// vertex store, undefined until written
	logic [VW-1:0] mem [DEPTH];
	logic [VW-1:0] rd_q;
	logic          rd_ok_q;
	logic [IDX_W-1:0] rd_idx;

	always_comb begin
		unique case (cmd.rd_sel)
			2'd0:    rd_idx = idx_a;
			2'd1:    rd_idx = idx_b;
			default: rd_idx = idx_c;
		endcase
	end

	// write port
	always_ff @(posedge clk) begin
		if (wr_en && ({20'd0, wr_idx} < 32'(MAX_VERTICES)))
			mem[wr_idx[AW-1:0]] <= {wx, wy, wz};
	end

	// registered read; out-of-range indexes read as zero
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q    <= mem[rd_idx[AW-1:0]];
			rd_ok_q <= ({20'd0, rd_idx} < 32'(MAX_VERTICES));
		end
	end

	logic signed [COORD_W-1:0] va_q [3];
	logic signed [COORD_W-1:0] vb_q [3];
	logic signed [COORD_W-1:0] vc_q [3];
	logic [VW-1:0] rd_val;
	assign rd_val = rd_ok_q ? rd_q : '0;

	// capture corners
	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			for (int k = 0; k < 3; k++) begin
				unique case (cmd.cap_sel)
					2'd0:    va_q[k] <= rd_val[VW-1-k*COORD_W -: COORD_W];
					2'd1:    vb_q[k] <= rd_val[VW-1-k*COORD_W -: COORD_W];
					default: vc_q[k] <= rd_val[VW-1-k*COORD_W -: COORD_W];
				endcase
			end
		end
	end

	// sums and edge differences
	logic signed [SW-1:0] sum_q [3];
	logic signed [EW-1:0] ab_q [3];
	logic signed [EW-1:0] ac_q [3];
	always_ff @(posedge clk) begin
		if (cmd.edge_en) begin
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= SW'(va_q[k]) + SW'(vb_q[k]) + SW'(vc_q[k]);
				ab_q[k]  <= EW'(va_q[k]) - EW'(vb_q[k]);
				ac_q[k]  <= EW'(va_q[k]) - EW'(vc_q[k]);
			end
		end
	end

	// centroid: divide by 3 via reciprocal multiply with correction
	localparam logic [CW-1:0] RECIP3 = 32'h5555_5556;
	logic [SW-1:0] smag [3];
	logic [SW+CW-1:0] qprod [3];
	logic [SW-1:0] q0 [3];
	logic [SW+1:0] back [3];
	logic [SW-1:0] qc [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			smag[k]  = sum_q[k][SW-1] ? SW'(-sum_q[k]) : SW'(sum_q[k]);
			qprod[k] = (SW+CW)'(smag[k]) * (SW+CW)'(RECIP3);
			q0[k]    = qprod[k][SW+CW-1:CW];
			back[k]  = (SW+2)'(q0[k]) * (SW+2)'(3);
			qc[k]    = ((SW+2)'(smag[k]) < back[k]) ? q0[k] - SW'(1) : q0[k];
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.cen_en) begin
			cen_x <= sum_q[0][SW-1] ? COORD_W'(-qc[0]) : COORD_W'(qc[0]);
			cen_y <= sum_q[1][SW-1] ? COORD_W'(-qc[1]) : COORD_W'(qc[1]);
			cen_z <= sum_q[2][SW-1] ? COORD_W'(-qc[2]) : COORD_W'(qc[2]);
		end
	end

	// cross product: one 25x25 product per step, accumulated into components
	logic signed [EW-1:0] ma, mb;
	logic signed [PW-1:0] prod;
	logic signed [CROSS_W-1:0] cr_q [3];
	always_comb begin
		unique case (cmd.mul_step)
			3'd0:    begin ma = ab_q[1]; mb = ac_q[2]; end
			3'd1:    begin ma = ab_q[2]; mb = ac_q[1]; end
			3'd2:    begin ma = ab_q[2]; mb = ac_q[0]; end
			3'd3:    begin ma = ab_q[0]; mb = ac_q[2]; end
			3'd4:    begin ma = ab_q[0]; mb = ac_q[1]; end
			default: begin ma = ab_q[1]; mb = ac_q[0]; end
		endcase
		prod = ma * mb;
	end
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			unique case (cmd.mul_step)
				3'd0: cr_q[0] <= CROSS_W'(prod);
				3'd1: cr_q[0] <= cr_q[0] - CROSS_W'(prod);
				3'd2: cr_q[1] <= CROSS_W'(prod);
				3'd3: cr_q[1] <= cr_q[1] - CROSS_W'(prod);
				3'd4: cr_q[2] <= CROSS_W'(prod);
				default: cr_q[2] <= cr_q[2] - CROSS_W'(prod);
			endcase
		end
	end

	// magnitudes of cross components
	logic [ROOT_W-1:0] cmag [3];
	always_comb begin
		for (int k = 0; k < 3; k++)
			cmag[k] = cr_q[k][CROSS_W-1] ? ROOT_W'(-cr_q[k]) : ROOT_W'(cr_q[k]);
	end

	// sum of squares: one square per step, split into 26-bit halves
	logic [ROOT_W-1:0] sqa;
	logic [25:0] sh, sl;
	logic [51:0] phh, phl_q, pll_q, phh_q;
	logic [SUM_W-1:0] s_q;
	always_comb begin
		unique case (cmd.sq_step)
			2'd0:    sqa = cmag[0];
			2'd1:    sqa = cmag[1];
			default: sqa = cmag[2];
		endcase
		sh  = 26'(sqa[ROOT_W-1:25]);
		sl  = {1'b0, sqa[24:0]};
		phh = 52'(sh) * 52'(sh);
	end
	// register partial products, then add to S next cycle
	logic sq_acc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_acc_q <= 1'b0;
		end else begin
			sq_acc_q <= cmd.sq_en;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			phh_q <= phh;
			phl_q <= 52'(sh) * 52'(sl);
			pll_q <= 52'(sl) * 52'(sl);
		end
		if (cmd.sq_en && cmd.sq_step == 2'd0)
			s_q <= '0;
		else if (sq_acc_q)
			s_q <= s_q + {phh_q, 50'd0} + (SUM_W'(phl_q) << 26) + SUM_W'(pll_q);
	end

	// square root, one bit per step, restoring method on a remainder
	logic [SUM_W-1:0] rrem_q;
	logic [ROOT_W-1:0] root_q;
	logic [5:0] rbit_q;
	logic [SUM_W+1:0] trial;
	always_comb begin
		trial = (SUM_W+2)'(rrem_q) - (((SUM_W+2)'(root_q) << (rbit_q + 6'd1))
		        + ((SUM_W+2)'(1) << {rbit_q, 1'b0}));
	end
	// remainder form: rem = S - root^2; try root | 2^b
	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			rrem_q <= s_q;
			root_q <= '0;
			rbit_q <= 6'(ROOT_W - 1);
		end else if (cmd.root_en) begin
			if (!trial[SUM_W+1]) begin
				rrem_q <= trial[SUM_W-1:0];
				root_q <= root_q | (ROOT_W'(1) << rbit_q);
			end
			rbit_q <= rbit_q - 6'd1;
		end
	end
	assign sts.root_done = (rbit_q == 6'd0);
	assign sts.degen     = (s_q == '0);

	// shared restoring divider for normal components
	logic [ROOT_W+1:0] drem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [4:0]        dcnt_q;
	logic              dneg_q;
	logic [ROOT_W+1:0] dshift, dsub;
	always_comb begin
		dshift = drem_q << 1;
		dsub   = dshift - (ROOT_W+2)'(root_q);
	end
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			// first quotient bit: |c| >= r
			if ((ROOT_W+2)'(cmag[cmd.div_sel]) >= (ROOT_W+2)'(root_q)) begin
				drem_q <= (ROOT_W+2)'(cmag[cmd.div_sel]) - (ROOT_W+2)'(root_q);
				quo_q  <= QUO_W'(1);
			end else begin
				drem_q <= (ROOT_W+2)'(cmag[cmd.div_sel]);
				quo_q  <= '0;
			end
			dneg_q <= cr_q[cmd.div_sel][CROSS_W-1];
			dcnt_q <= 5'd0;
		end else if (cmd.div_en) begin
			if (!dsub[ROOT_W+1]) begin
				drem_q <= dsub;
				quo_q  <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				drem_q <= dshift;
				quo_q  <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 5'd1;
		end
	end
	assign sts.div_done = (dcnt_q == 5'd29) && cmd.div_en;

	logic [NORM_W-1:0] qfin;
	logic [QUO_W-1:0]  qlast;
	assign qlast = dsub[ROOT_W+1] ? {quo_q[QUO_W-2:0], 1'b0} : {quo_q[QUO_W-2:0], 1'b1};
	assign qfin  = dneg_q ? NORM_W'(-NORM_W'(qlast)) : NORM_W'(qlast);

	// clear the normal for a degenerate face, else store the finished component
	always_ff @(posedge clk) begin
		if (cmd.root_init && sts.degen) begin
			nrm_x <= '0; nrm_y <= '0; nrm_z <= '0;
		end else if (cmd.div_store) begin
			unique case (cmd.div_sel)
				2'd0:    nrm_x <= qfin;
				2'd1:    nrm_y <= qfin;
				default: nrm_z <= qfin;
			endcase
		end
	end

	// length: r >> 16, saturating
	assign nrm_len = sts.degen ? '0 :
		((root_q[ROOT_W-1:48] != '0) ? '1 : root_q[47:16]);

endmodule

### hdl/tnc_ctrl.sv
// Controller of the triangle normal and centroid block.
// Sequences store reads, products, root and division steps.
// Depends on tnc_pkg.
module tnc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               opcode,
	output logic               busy,
	output logic               wr_en,
	output logic               idx_ld,
	output logic               done,
	output tnc_pkg::tnc_cmd_t  cmd,
	input  tnc_pkg::tnc_sts_t  sts
);
	import tnc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_EDGE = 4'd2;
	localparam logic [3:0] ST_MUL  = 4'd3;
	localparam logic [3:0] ST_SQ   = 4'd4;
	localparam logic [3:0] ST_SQW  = 4'd5;
	localparam logic [3:0] ST_RINI = 4'd6;
	localparam logic [3:0] ST_ROOT = 4'd7;
	localparam logic [3:0] ST_DINI = 4'd8;
	localparam logic [3:0] ST_DIV  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0] st_q;
	logic [2:0] cnt_q;
	logic [1:0] comp_q;

	assign busy   = (st_q != ST_IDLE);
	assign wr_en  = start && !busy && (opcode == OP_WRITE);
	assign idx_ld = start && !busy;
	assign done   = (st_q == ST_DONE);

	// decode commands
	always_comb begin
		cmd = '0;
		cmd.rd_sel   = cnt_q[1:0];
		cmd.cap_sel  = cnt_q[1:0] - 2'd1;
		cmd.mul_step = cnt_q;
		cmd.sq_step  = cnt_q[1:0];
		cmd.div_sel  = comp_q;
		unique case (st_q)
			ST_RD: begin
				cmd.rd_en  = (cnt_q < 3'd3);
				cmd.cap_en = (cnt_q != 3'd0);
			end
			ST_EDGE: cmd.edge_en = 1'b1;
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.cen_en = 1'b1;
			end
			ST_SQ:   cmd.sq_en = 1'b1;
			ST_RINI: cmd.root_init = 1'b1;
			ST_ROOT: cmd.root_en = 1'b1;
			ST_DINI: cmd.div_init = 1'b1;
			ST_DIV: begin
				cmd.div_en    = 1'b1;
				cmd.div_store = sts.div_done;
			end
			default: ;
		endcase
	end

	// advance sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= 3'd0;
			comp_q <= 2'd0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					cnt_q <= 3'd0;
					if (start && opcode == OP_TRI)
						st_q <= ST_RD;
				end
				ST_RD: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						st_q  <= ST_EDGE;
						cnt_q <= 3'd0;
					end
				end
				ST_EDGE: st_q <= ST_MUL;
				ST_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) begin
						st_q  <= ST_SQ;
						cnt_q <= 3'd0;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd2)
						st_q <= ST_SQW;
				end
				ST_SQW: st_q <= ST_RINI;
				ST_RINI: st_q <= sts.degen ? ST_DONE : ST_ROOT;
				ST_ROOT: begin
					if (sts.root_done) begin
						st_q   <= ST_DINI;
						comp_q <= 2'd0;
					end
				end
				ST_DINI: st_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_done) begin
						if (comp_q == 2'd2) begin
							st_q <= ST_DONE;
						end else begin
							comp_q <= comp_q + 2'd1;
							st_q   <= ST_DINI;
						end
					end
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/triangle_normal_centroid_top.sv
// Top level of the triangle normal and centroid block.
// Joins tnc_ctrl and tnc_datapath; depends on tnc_pkg.
//
//  channel | handshake          | fields
//  --------+--------------------+------------------------------------------
//  command | start / busy       | opcode, vertex_*_index, coord_x/y/z
//  result  | strobe (one cycle) | centroid_*, normal_*, normal_length, degenerate
//
// A vertex write leaves busy low. A triangle holds busy up to and including the
// cycle in which it strobes its result; the next transaction can be taken in the
// cycle after that. The sequence runs the store reads, six product steps, three
// square steps, the 51-step square root and three 31-bit divisions on one shared
// divider; a degenerate face skips the root and the divisions. Reset clears the
// sequencing state only; the store is undefined until written. The receiver
// cannot stall: each result is shown for exactly one cycle.
module triangle_normal_centroid_top #(
	parameter int MAX_VERTICES = tnc_pkg::MAX_VERTICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic opcode,
	input  logic [tnc_pkg::IDX_W-1:0] vertex_a_index,
	input  logic [tnc_pkg::IDX_W-1:0] vertex_b_index,
	input  logic [tnc_pkg::IDX_W-1:0] vertex_c_index,
	input  logic signed [tnc_pkg::COORD_W-1:0] coord_x,
	input  logic signed [tnc_pkg::COORD_W-1:0] coord_y,
	input  logic signed [tnc_pkg::COORD_W-1:0] coord_z,
	output logic strobe,
	output logic signed [tnc_pkg::COORD_W-1:0] centroid_x,
	output logic signed [tnc_pkg::COORD_W-1:0] centroid_y,
	output logic signed [tnc_pkg::COORD_W-1:0] centroid_z,
	output logic signed [tnc_pkg::NORM_W-1:0] normal_x,
	output logic signed [tnc_pkg::NORM_W-1:0] normal_y,
	output logic signed [tnc_pkg::NORM_W-1:0] normal_z,
	output logic [tnc_pkg::LEN_W-1:0] normal_length,
	output logic degenerate
);
	import tnc_pkg::*;

	tnc_cmd_t cmd;
	tnc_sts_t sts;
	logic wr_en, idx_ld, done;
	logic [IDX_W-1:0] ia_q, ib_q, ic_q;

	// hold triangle indexes for the whole transaction
	always_ff @(posedge clk) begin
		if (idx_ld) begin
			ia_q <= vertex_a_index;
			ib_q <= vertex_b_index;
			ic_q <= vertex_c_index;
		end
	end

	tnc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.busy(busy), .wr_en(wr_en), .idx_ld(idx_ld), .done(done),
		.cmd(cmd), .sts(sts)
	);

	tnc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.wr_en(wr_en), .wr_idx(vertex_a_index),
		.idx_a(ia_q), .idx_b(ib_q), .idx_c(ic_q),
		.wx(coord_x), .wy(coord_y), .wz(coord_z),
		.cen_x(centroid_x), .cen_y(centroid_y), .cen_z(centroid_z),
		.nrm_x(normal_x), .nrm_y(normal_y), .nrm_z(normal_z),
		.nrm_len(normal_length)
	);

	assign strobe     = done;
	assign degenerate = sts.degen;

endmodule

### hdl/tnc_checker.sv
// Port-level checker for the triangle normal and centroid block.
// Bound to triangle_normal_centroid_top; depends on tnc_pkg.
module tnc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic strobe,
	input logic degenerate,
	input logic [31:0] normal_x,
	input logic [31:0] normal_length
);
	import tnc_pkg::*;

	// a write never raises busy
	a_wr_nobusy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_WRITE |=> !busy)
		else $error("busy after vertex write");

	// a triangle transaction raises busy
	a_tri_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_TRI |=> busy)
		else $error("triangle not taken");

	// result only at the end of a busy transaction
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy ##1 !busy)
		else $error("strobe outside transaction");

	// degenerate face gives zero x normal component and zero length
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && degenerate |-> normal_x == '0 && normal_length == '0)
		else $error("degenerate result not zero");

endmodule

bind triangle_normal_centroid_top tnc_checker u_tnc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
	.strobe(strobe), .degenerate(degenerate), .normal_x(normal_x),
	.normal_length(normal_length)
);

### sim/testbench.sv
// Testbench for triangle_normal_centroid_top: vertex writes and triangle faces.
// Predicts centroid, unit normal and length per face and compares each strobed result.
// Depends on tnc_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import tnc_pkg::*;

	typedef struct {
		logic signed [COORD_W-1:0] cx, cy, cz;
		logic signed [NORM_W-1:0]  nx, ny, nz;
		logic [LEN_W-1:0]          len;
		logic                      degen;
	} face_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = OP_WRITE;
	logic [IDX_W-1:0] vertex_a_index = '0, vertex_b_index = '0, vertex_c_index = '0;
	logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic strobe;
	logic signed [COORD_W-1:0] centroid_x, centroid_y, centroid_z;
	logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
	logic [LEN_W-1:0] normal_length;
	logic degenerate;

	// predictor state: shadow of the vertex store and which entries are valid
	logic signed [COORD_W-1:0] shadow_x [4096];
	logic signed [COORD_W-1:0] shadow_y [4096];
	logic signed [COORD_W-1:0] shadow_z [4096];
	bit written [4096];
	int written_list[$];
	face_t face_queue[$];

	int errors = 0;
	int faces_checked = 0;
	int writes_sent = 0;
	int degen_seen = 0;
	bit quiet = 1'b0;

	triangle_normal_centroid_top u_dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// floor(sqrt(s)) bit by bit over the 51-bit root range
	function automatic logic [63:0] int_root(input logic [127:0] s);
		logic [63:0] r;
		logic [63:0] cand;
		r = '0;
		for (int b = 50; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (128'(cand) * 128'(cand) <= s)
				r = cand;
		end
		return r;
	endfunction

	// sign(c) * floor(|c| * 2^30 / r), truncated toward zero
	function automatic logic signed [NORM_W-1:0] unit_part(input logic signed [63:0] c,
			input logic [63:0] r);
		logic [127:0] mag;
		logic [127:0] q;
		mag = (c < 0) ? 128'(-c) : 128'(c);
		q = (mag << 30) / 128'(r);
		return (c < 0) ? -NORM_W'(q) : NORM_W'(q);
	endfunction

	function automatic face_t predict_face(input int ia, input int ib, input int ic);
		face_t f;
		logic signed [63:0] a[3], b[3], c[3], ab[3], ac[3], cr[3], sum;
		logic [127:0] s;
		logic [63:0] r;
		a = '{shadow_x[ia], shadow_y[ia], shadow_z[ia]};
		b = '{shadow_x[ib], shadow_y[ib], shadow_z[ib]};
		c = '{shadow_x[ic], shadow_y[ic], shadow_z[ic]};
		for (int k = 0; k < 3; k++) begin
			sum = a[k] + b[k] + c[k];
			// signed division in SV truncates toward zero
			sum = sum / 3;
			if (k == 0) f.cx = sum[COORD_W-1:0];
			if (k == 1) f.cy = sum[COORD_W-1:0];
			if (k == 2) f.cz = sum[COORD_W-1:0];
			ab[k] = a[k] - b[k];
			ac[k] = a[k] - c[k];
		end
		cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
		cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
		cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
		s = '0;
		for (int k = 0; k < 3; k++)
			s += 128'(cr[k] < 0 ? -cr[k] : cr[k]) * 128'(cr[k] < 0 ? -cr[k] : cr[k]);
		if (s == 0) begin
			f.nx = '0; f.ny = '0; f.nz = '0; f.len = '0; f.degen = 1'b1;
		end else begin
			r = int_root(s);
			f.nx = unit_part(cr[0], r);
			f.ny = unit_part(cr[1], r);
			f.nz = unit_part(cr[2], r);
			f.len = ((r >> 16) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : LEN_W'(r >> 16);
			f.degen = 1'b0;
		end
		return f;
	endfunction

	// send one transaction; waits until the block accepts it
	task automatic send_item(input logic op, input int ia, input int ib, input int ic,
			input int x, input int y, input int z);
		if (!quiet && $urandom_range(99) < 29) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		vertex_a_index <= ia[IDX_W-1:0];
		vertex_b_index <= ib[IDX_W-1:0];
		vertex_c_index <= ic[IDX_W-1:0];
		coord_x <= x[COORD_W-1:0];
		coord_y <= y[COORD_W-1:0];
		coord_z <= z[COORD_W-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		// accepted at this edge: update predictor
		if (op == OP_WRITE) begin
			shadow_x[ia] = x[COORD_W-1:0];
			shadow_y[ia] = y[COORD_W-1:0];
			shadow_z[ia] = z[COORD_W-1:0];
			if (!written[ia]) written_list.push_back(ia);
			written[ia] = 1'b1;
			writes_sent++;
		end else begin
			face_queue.push_back(predict_face(ia, ib, ic));
		end
	endtask

	function automatic int rand_coord();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 8388607 : -8388608;
			1: return $signed($urandom_range(511)) - 256;
			default: return $signed(24'($urandom));
		endcase
	endfunction

	function automatic int pick_written();
		return written_list[$urandom_range(written_list.size() - 1)];
	endfunction

	task automatic send_vertex(input int idx, input int x, input int y, input int z);
		send_item(OP_WRITE, idx, $urandom_range(4095), $urandom_range(4095), x, y, z);
	endtask

	task automatic send_face(input int ia, input int ib, input int ic);
		send_item(OP_TRI, ia, ib, ic, rand_coord(), rand_coord(), rand_coord());
	endtask

	// extremes of coordinates and indices, degenerate and tiny faces
	task automatic test_directed();
		send_vertex(0, 0, 0, 0);
		send_vertex(4095, 8388607, 8388607, 8388607);
		send_vertex(1, -8388608, -8388608, -8388608);
		send_vertex(2, 8388607, -8388608, 0);
		send_vertex(3, -8388608, 0, 8388607);
		send_vertex(4, 1, 0, 0);
		send_vertex(5, 0, 1, 0);
		send_vertex(6, 0, 0, 1);
		send_vertex(2730, 65536, 0, 0);
		send_face(0, 0, 0);          // all corners equal
		send_face(4095, 1, 0);       // collinear, degenerate
		send_face(4095, 2, 3);       // large cross, saturating length
		send_face(1, 2, 3);
		send_face(0, 4, 5);          // tiny nonzero cross, length truncates to zero
		send_face(4, 5, 6);
		send_face(2730, 4095, 1);
		send_face(1, 1, 4095);
		// rewrite an entry and read it back
		send_vertex(4, -1, -1, -1);
		send_face(4, 0, 6);
		send_face(3, 2, 4095);
	endtask

	// mostly faces over written vertices, with fresh writes mixed in
	task automatic test_random(input int n);
		int ia;
		for (int i = 0; i < n; i++) begin
			quiet = (i >= n / 3) && (i < n / 2);
			if ($urandom_range(99) < 35) begin
				send_vertex($urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
			end else if ($urandom_range(9) == 0) begin
				ia = pick_written();
				send_face(ia, ia, pick_written());
			end else begin
				send_face(pick_written(), pick_written(), pick_written());
			end
		end
		quiet = 1'b0;
	endtask

	// check each strobed result against the oldest prediction
	always @(posedge clk) begin
		face_t e;
		if (arst_n && strobe) begin
			if (face_queue.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result at %0t", $time);
			end else begin
				e = face_queue.pop_front();
				faces_checked++;
				if (e.degen) degen_seen++;
				if (centroid_x !== e.cx || centroid_y !== e.cy || centroid_z !== e.cz ||
						normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
						normal_length !== e.len || degenerate !== e.degen) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch face %0d: exp c=%0d %0d %0d n=%0d %0d %0d l=%0h d=%0b",
							faces_checked, e.cx, e.cy, e.cz, e.nx, e.ny, e.nz, e.len,
							e.degen);
						$display("  got c=%0d %0d %0d n=%0d %0d %0d l=%0h d=%0b",
							centroid_x, centroid_y, centroid_z, normal_x, normal_y,
							normal_z, normal_length, degenerate);
					end
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1530);
		start <= 1'b0;
		while (face_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d vertex writes and %0d faces (%0d degenerate)",
			writes_sent, faces_checked, degen_seen);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
